FILE: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared widths and codes for the buddy page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	localparam int OW = 4;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/bpa_page_ram.sv
// ----------------------------------------------------------------------------
// bpa_page_ram
// single port page table memory, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_page_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 27
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// buddy allocator with per-order fifo free lists in a page table memory
// alloc searches upward from the requested order, then splits the block down;
//   free merges with free buddies level by level;
//   init frees each of the count pages in turn
// one item at a time; each list update goes through the page memory, writing only the links that change
// after reset a clearing pass over all MAX_PAGES entries runs before the first item
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_core
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 1024,
	parameter int MAX_ORDER = 11
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [$clog2(MAX_PAGES):0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   opcode,
	input  wire logic [OW-1:0]                req_order,
	input  wire logic [$clog2(MAX_PAGES)-1:0] page_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              status,
	output logic [$clog2(MAX_PAGES)-1:0]      block_index,
	output logic [OW-1:0]                     block_order,
	output logic [$clog2(MAX_PAGES):0]        free_pages
);

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int LW  = PW + 1;
	localparam int WW  = 1 + OW + 2 * LW;
	localparam int OIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [LW-1:0] NIL = LW'(MAX_PAGES);

	localparam logic [5:0] S_IDLE = 6'd0,  S_CLR = 6'd1,  S_I0 = 6'd2,  S_I1 = 6'd3;
	localparam logic [5:0] S_I2 = 6'd4,  S_I3 = 6'd5,  S_Q0 = 6'd6,  S_Q1 = 6'd7;
	localparam logic [5:0] S_F0 = 6'd8,  S_F1 = 6'd9,  S_F2 = 6'd10, S_F3 = 6'd11;
	localparam logic [5:0] S_F4 = 6'd12, S_F5 = 6'd13, S_F6 = 6'd14, S_P0 = 6'd15;
	localparam logic [5:0] S_P1 = 6'd16, S_P2 = 6'd17, S_P3 = 6'd18, S_P4 = 6'd19;
	localparam logic [5:0] S_U0 = 6'd20, S_U1 = 6'd21, S_U2 = 6'd22, S_U3 = 6'd23;
	localparam logic [5:0] S_U4 = 6'd24, S_U5 = 6'd25, S_U6 = 6'd26, S_U7 = 6'd27;
	localparam logic [5:0] S_A0 = 6'd28, S_A1 = 6'd29, S_A2 = 6'd30, S_A3 = 6'd31;
	localparam logic [5:0] S_A4 = 6'd32, S_A5 = 6'd33, S_A6 = 6'd34, S_A7 = 6'd35;
	localparam logic [5:0] S_A8 = 6'd36, S_A9 = 6'd37, S_A10 = 6'd38, S_DONE = 6'd39;

	logic [5:0]    state_q, ret_q, fret_q;
	logic [LW-1:0] pcnt_q, ftot_q, i_q, t_q, pr_q, nx_q;
	logic [PW-1:0] p_q, b_q, ap_q, pidx_q;
	logic [OW-1:0] o_q, ao_q, req_q;
	logic [OW:0]   sc_q;
	logic          rs_status_q;
	logic [PW-1:0] rs_bidx_q;
	logic [OW-1:0] rs_bord_q;
	logic          out_valid_q, status_q;
	logic [PW-1:0] bidx_q;
	logic [OW-1:0] bord_q;
	logic [LW-1:0] fp_q;
	logic [LW-1:0] head_q [MAX_ORDER];
	logic [LW-1:0] tail_q [MAX_ORDER];
	logic [LW-1:0] cntl_q [MAX_ORDER];

	logic [PW-1:0] mem_addr;
	logic          mem_we;
	logic [WW-1:0] mem_wdata, rdata;
	logic          rd_alloc;
	logic [OW-1:0] rd_ord, oc, lo;
	logic [LW-1:0] rd_nxt, rd_prv, cnt, tl;
	logic [31:0]   bud_f, bud_a, mmask;
	logic [PW-1:0] mval;
	logic [OIW-1:0] ai, si;

	bpa_page_ram #(.DEPTH(MAX_PAGES), .WIDTH(WW)) u_ram (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	assign rd_alloc = rdata[WW-1];
	assign rd_ord   = rdata[WW-2 -: OW];
	assign rd_nxt   = rdata[2*LW-1:LW];
	assign rd_prv   = rdata[LW-1:0];
	assign cnt      = (pcnt_q > NIL) ? NIL : pcnt_q;
	assign oc       = ({1'b0, rd_ord} >= (OW+1)'(MAX_ORDER)) ? OW'(MAX_ORDER - 1) : rd_ord;
	assign lo       = o_q - OW'(1);
	assign bud_f    = 32'(p_q) ^ (32'd1 << o_q);
	assign bud_a    = 32'(p_q) ^ (32'd1 << lo);
	assign mmask    = ~((32'd2 << o_q) - 32'd1);
	assign mval     = p_q & mmask[PW-1:0];
	assign ai       = ao_q[OIW-1:0];
	assign si       = sc_q[OIW-1:0];
	assign tl       = tail_q[ai];

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = bidx_q;
	assign block_order = bord_q;
	assign free_pages  = fp_q;

	always_comb begin
		mem_addr  = p_q;
		mem_we    = 1'b0;
		mem_wdata = rdata;
		case (state_q)
			S_CLR, S_I1: begin
				mem_addr  = i_q[PW-1:0];
				mem_we    = 1'b1;
				mem_wdata = {1'b1, {OW{1'b0}}, {(2*LW){1'b0}}};
			end
			S_Q0: mem_addr = pidx_q;
			S_F1: begin
				mem_we           = 1'b1;
				mem_wdata[WW-1]  = 1'b0;
			end
			S_F2: mem_addr = bud_f[PW-1:0];
			S_F5: mem_addr = mval;
			S_F6: begin
				mem_we                = 1'b1;
				mem_wdata[WW-1]       = 1'b0;
				mem_wdata[WW-2 -: OW] = o_q + OW'(1);
			end
			S_P0: mem_addr = ap_q;
			S_P1: begin
				mem_addr              = ap_q;
				mem_we                = 1'b1;
				mem_wdata[2*LW-1:LW]  = NIL;
				mem_wdata[LW-1:0]     = tl;
			end
			S_P2: mem_addr = t_q[PW-1:0];
			S_P3: begin
				mem_addr             = t_q[PW-1:0];
				mem_we               = 1'b1;
				mem_wdata[2*LW-1:LW] = LW'(ap_q);
			end
			S_U0: mem_addr = ap_q;
			S_U2: mem_addr = pr_q[PW-1:0];
			S_U3: begin
				mem_addr             = pr_q[PW-1:0];
				mem_we               = 1'b1;
				mem_wdata[2*LW-1:LW] = nx_q;
			end
			S_U5: mem_addr = nx_q[PW-1:0];
			S_U6: begin
				mem_addr          = nx_q[PW-1:0];
				mem_we            = 1'b1;
				mem_wdata[LW-1:0] = pr_q;
			end
			S_A4: mem_addr = b_q;
			S_A5: begin
				mem_addr              = b_q;
				mem_we                = 1'b1;
				mem_wdata[WW-1]       = 1'b0;
				mem_wdata[WW-2 -: OW] = lo;
			end
			S_A7: begin
				mem_we                = 1'b1;
				mem_wdata[WW-1]       = 1'b0;
				mem_wdata[WW-2 -: OW] = lo;
			end
			S_A10: begin
				mem_we          = 1'b1;
				mem_wdata[WW-1] = 1'b1;
			end
			default: begin
				mem_addr = p_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= S_IDLE;
			fret_q      <= S_DONE;
			pcnt_q      <= NIL;
			ftot_q      <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_ORDER; k++) begin
				head_q[k] <= NIL;
				tail_q[k] <= NIL;
				cntl_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				pcnt_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					i_q <= i_q + LW'(1);
					if (i_q == LW'(MAX_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q       <= req_order;
						pidx_q      <= page_index;
						sc_q        <= {1'b0, req_order};
						rs_status_q <= ST_OK;
						rs_bidx_q   <= '0;
						rs_bord_q   <= '0;
						case (opcode)
							OP_INIT:  state_q <= S_I0;
							OP_ALLOC: state_q <= S_A0;
							OP_FREE:  state_q <= S_Q0;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_I0: begin
					for (int k = 0; k < MAX_ORDER; k++) begin
						head_q[k] <= NIL;
						tail_q[k] <= NIL;
						cntl_q[k] <= '0;
					end
					ftot_q  <= '0;
					i_q     <= '0;
					state_q <= (cnt == '0) ? S_DONE : S_I1;
				end
				S_I1: begin
					if (i_q == cnt - LW'(1)) begin
						i_q     <= '0;
						state_q <= S_I2;
					end else begin
						i_q <= i_q + LW'(1);
					end
				end
				S_I2: begin
					p_q     <= i_q[PW-1:0];
					fret_q  <= S_I3;
					state_q <= S_F0;
				end
				S_I3: begin
					if (i_q + LW'(1) == cnt) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + LW'(1);
						state_q <= S_I2;
					end
				end
				S_Q0: state_q <= S_Q1;
				S_Q1: begin
					if ((LW'(pidx_q) < cnt) && rd_alloc) begin
						p_q     <= pidx_q;
						fret_q  <= S_DONE;
						state_q <= S_F0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					o_q     <= oc;
					ftot_q  <= ftot_q + (LW'(1) << oc);
					ao_q    <= oc;
					ap_q    <= p_q;
					ret_q   <= S_F2;
					state_q <= S_P0;
				end
				S_F2: begin
					if (o_q >= OW'(MAX_ORDER - 1) || bud_f >= 32'(cnt)) begin
						state_q <= fret_q;
					end else begin
						b_q     <= bud_f[PW-1:0];
						state_q <= S_F3;
					end
				end
				S_F3: begin
					if (rd_ord != o_q || rd_alloc) begin
						state_q <= fret_q;
					end else begin
						ao_q    <= o_q;
						ap_q    <= b_q;
						ret_q   <= S_F4;
						state_q <= S_U0;
					end
				end
				S_F4: begin
					ao_q    <= o_q;
					ap_q    <= p_q;
					ret_q   <= S_F5;
					state_q <= S_U0;
				end
				S_F5: begin
					p_q     <= mval;
					state_q <= S_F6;
				end
				S_F6: begin
					o_q     <= o_q + OW'(1);
					ao_q    <= o_q + OW'(1);
					ap_q    <= p_q;
					ret_q   <= S_F2;
					state_q <= S_P0;
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					t_q <= tl;
					if (tl < NIL) begin
						state_q <= S_P2;
					end else begin
						head_q[ai] <= LW'(ap_q);
						state_q    <= S_P4;
					end
				end
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: begin
					tail_q[ai] <= LW'(ap_q);
					cntl_q[ai] <= cntl_q[ai] + LW'(1);
					state_q    <= ret_q;
				end
				S_U0: state_q <= S_U1;
				S_U1: begin
					pr_q <= rd_prv;
					nx_q <= rd_nxt;
					if (rd_prv < NIL) begin
						state_q <= S_U2;
					end else begin
						head_q[ai] <= rd_nxt;
						state_q    <= S_U4;
					end
				end
				S_U2: state_q <= S_U3;
				S_U3: state_q <= S_U4;
				S_U4: begin
					if (nx_q < NIL) begin
						state_q <= S_U5;
					end else begin
						tail_q[ai] <= pr_q;
						state_q    <= S_U7;
					end
				end
				S_U5: state_q <= S_U6;
				S_U6: state_q <= S_U7;
				S_U7: begin
					cntl_q[ai] <= cntl_q[ai] - LW'(1);
					state_q    <= ret_q;
				end
				S_A0: begin
					if ({1'b0, req_q} >= (OW+1)'(MAX_ORDER) || sc_q >= (OW+1)'(MAX_ORDER)) begin
						rs_status_q <= ST_FAIL;
						state_q     <= S_DONE;
					end else if (cntl_q[si] != '0 && head_q[si] < NIL) begin
						p_q     <= head_q[si][PW-1:0];
						state_q <= S_A1;
					end else begin
						sc_q <= sc_q + (OW+1)'(1);
					end
				end
				S_A1: state_q <= S_A2;
				S_A2: begin
					o_q     <= oc;
					state_q <= S_A3;
				end
				S_A3: begin
					if (o_q == req_q || o_q == '0 || bud_a >= 32'(cnt)) begin
						state_q <= S_A8;
					end else begin
						b_q     <= bud_a[PW-1:0];
						ao_q    <= o_q;
						ap_q    <= p_q;
						ret_q   <= S_A4;
						state_q <= S_U0;
					end
				end
				S_A4: state_q <= S_A5;
				S_A5: begin
					ao_q    <= lo;
					ap_q    <= b_q;
					ret_q   <= S_A6;
					state_q <= S_P0;
				end
				S_A6: state_q <= S_A7;
				S_A7: begin
					o_q     <= lo;
					ao_q    <= lo;
					ap_q    <= p_q;
					ret_q   <= S_A3;
					state_q <= S_P0;
				end
				S_A8: begin
					ao_q    <= o_q;
					ap_q    <= p_q;
					ret_q   <= S_A9;
					state_q <= S_U0;
				end
				S_A9: state_q <= S_A10;
				S_A10: begin
					ftot_q    <= ftot_q - (LW'(1) << o_q);
					rs_bidx_q <= p_q;
					rs_bord_q <= o_q;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= rs_status_q;
						bidx_q      <= rs_bidx_q;
						bord_q      <= rs_bord_q;
						fp_q        <= ftot_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("page memory written while idle");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == S_IDLE))
		else $error("finished item not moved to output register");

	a_list_return: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P4 || state_q == S_U7) |-> (ret_q != S_IDLE && ret_q != S_CLR))
		else $error("list update returns to a bad state");
`endif

endmodule

`default_nettype wire
